### hdl/ipfp_pkg.sv
// Package for the IMU packet field parser: packet codes, status codes and
// the shared types of the vector store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ipfp_pkg;

    // Packet and field descriptors
    localparam logic [7:0]  PKT_DESC_IMU = 8'h80;
    localparam logic [7:0]  FIELD_ACCEL  = 8'h04;
    localparam logic [7:0]  FIELD_GYRO   = 8'h05;

    // -999.0 as IEEE single, given for every vector word on a bad descriptor
    localparam logic [31:0] ERROR_WORD   = 32'hC479C000;

    // Field offsets bounding the three captured words
    localparam logic [7:0]  CAP_FIRST    = 8'd2;
    localparam logic [7:0]  CAP_LAST     = 8'd13;
    localparam logic [7:0]  MIN_VEC_LEN  = 8'd14;
    localparam logic [7:0]  MIN_FIELD_LEN = 8'd2;

    localparam int          VEC_W        = 96;
    localparam int          OUT_W        = 200;

    typedef logic [VEC_W-1:0] vec_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_DESC = 2'd1,
        STATUS_BAD_LEN  = 2'd2
    } status_t;

    // Slot in the vector memory
    typedef enum logic {
        SLOT_ACCEL = 1'b0,
        SLOT_GYRO  = 1'b1
    } slot_t;

    // Write of one completed vector into the store
    typedef struct packed {
        logic  valid;
        slot_t slot;
        vec_t  data;
    } commit_t;

endpackage

`default_nettype wire

### hdl/imu_packet_field_parser.sv
// Top level of the IMU packet field parser: byte-wise packet walker, result
// stages and assertions. Depends on ipfp_pkg and ipfp_vec_store.
`timescale 1ns / 1ps
`default_nettype none

// Takes one packet byte per cycle with no gaps required: s_tready stays high
// unless both result stages are full and the output is stalled. At most one
// result request is given per packet, on the byte that settles it (the
// descriptor byte, the length byte, a field length below two, or the last
// payload byte); the result then waits in stage A for the registered read of
// the two-entry vector memory that holds the last complete accel and gyro
// vectors. Bytes before the first packet start, and after a result until the
// next start, are dropped. Sync bytes and checksum are not checked.
module imu_packet_field_parser
    import ipfp_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output      logic             s_tready,
    input  wire logic [7:0]       s_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]       s_tuser,   // [0] packet_start
    output      logic             m_tvalid,
    input  wire logic             m_tready,
    // [1:0] status, [33:2] accel_x, [65:34] accel_y, [97:66] accel_z,
    // [129:98] gyro_x, [161:130] gyro_y, [193:162] gyro_z,
    // [194] accel_seen, [195] gyro_seen, [199:196] zero
    output      logic [OUT_W-1:0] m_tdata
);

    // Walker state
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  plen_reg, plen_next;
    logic [7:0]  foff_reg, foff_next;
    logic [7:0]  flen_reg, flen_next;
    logic [7:0]  kind_reg, kind_next;
    vec_t        cap_reg, cap_next;
    logic [1:0]  seen_reg, seen_next;
    logic        ignore_reg, ignore_next;

    // Result stages
    logic        a_valid_reg, a_valid_next;
    status_t     a_status_reg;
    logic [1:0]  a_seen_reg;
    logic        b_valid_reg, b_valid_next;
    logic [OUT_W-1:0] b_data_reg;

    logic        in_acc;
    logic        a_move;
    logic        emit;
    status_t     emit_status;
    commit_t     commit;
    vec_t        accel_vec;
    vec_t        gyro_vec;
    logic [OUT_W-1:0] b_data_next;

    assign in_acc   = s_tvalid && s_tready;
    assign a_move   = a_valid_reg && (!b_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || a_move;
    assign m_tvalid = b_valid_reg;
    assign m_tdata  = b_data_reg;

    // Packet walker: next state, result request and vector commit
    always_comb
    begin
        logic       start;
        logic       active;
        logic [8:0] p;
        logic [7:0] b;
        logic [7:0] foff_inc;
        logic       early;

        start    = s_tuser[0];
        b        = s_tdata;
        active   = in_acc && (start || !ignore_reg);
        p        = start ? 9'd0 : pos_reg;
        foff_inc = foff_reg + 8'd1;
        early    = 1'b0;

        pos_next    = pos_reg;
        plen_next   = plen_reg;
        foff_next   = foff_reg;
        flen_next   = flen_reg;
        kind_next   = kind_reg;
        cap_next    = cap_reg;
        seen_next   = seen_reg;
        ignore_next = ignore_reg;
        emit        = 1'b0;
        emit_status = STATUS_OK;
        commit      = '{valid: 1'b0, slot: SLOT_ACCEL, data: cap_reg};

        if (active)
        begin
            if (start)
            begin
                seen_next   = 2'b00;
                ignore_next = 1'b0;
            end
            pos_next = (p != 9'h1FF) ? p + 9'd1 : p;

            if (p == 9'd2)
            begin
                if (b != PKT_DESC_IMU)
                begin
                    emit        = 1'b1;
                    emit_status = STATUS_BAD_DESC;
                end
            end
            else if (p == 9'd3)
            begin
                plen_next = b;
                foff_next = 8'd0;
                if (b == 8'd0)
                begin
                    emit = 1'b1;
                end
            end
            else if (p >= 9'd4)
            begin
                if (foff_reg == 8'd0)
                begin
                    flen_next = b;
                    if (b < MIN_FIELD_LEN)
                    begin
                        emit        = 1'b1;
                        emit_status = STATUS_BAD_LEN;
                        early       = 1'b1;
                    end
                end
                else if (foff_reg == 8'd1)
                begin
                    kind_next = b;
                end
                else if (foff_reg <= CAP_LAST && flen_reg >= MIN_VEC_LEN &&
                         (kind_reg == FIELD_ACCEL || kind_reg == FIELD_GYRO))
                begin
                    cap_next = {cap_reg[VEC_W-9:0], b};
                    if (foff_reg == CAP_LAST)
                    begin
                        commit.valid = 1'b1;
                        commit.slot  = (kind_reg == FIELD_ACCEL) ? SLOT_ACCEL : SLOT_GYRO;
                        commit.data  = cap_next;
                        seen_next    = seen_next |
                                       ((kind_reg == FIELD_ACCEL) ? 2'b01 : 2'b10);
                    end
                end

                // Offset advance and end-of-payload check
                if (!early)
                begin
                    foff_next = (foff_inc == flen_next) ? 8'd0 : foff_inc;
                    if ({1'b0, p} == 10'd3 + {2'b00, plen_reg})
                    begin
                        emit = 1'b1;
                    end
                end
            end

            if (emit)
            begin
                ignore_next = 1'b1;
            end
        end
    end

    // Walker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            plen_reg   <= '0;
            foff_reg   <= '0;
            flen_reg   <= '0;
            kind_reg   <= '0;
            cap_reg    <= '0;
            seen_reg   <= '0;
            ignore_reg <= 1'b1;
        end
        else
        begin
            pos_reg    <= pos_next;
            plen_reg   <= plen_next;
            foff_reg   <= foff_next;
            flen_reg   <= flen_next;
            kind_reg   <= kind_next;
            cap_reg    <= cap_next;
            seen_reg   <= seen_next;
            ignore_reg <= ignore_next;
        end
    end

    // Completed vectors, read when a result is requested
    ipfp_vec_store u_vec_store (
        .clk       (clk),
        .commit    (commit),
        .rd_en     (emit),
        .accel_vec (accel_vec),
        .gyro_vec  (gyro_vec)
    );

    // Stage A waits for the memory read; stage B is the output register
    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (emit)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end

        b_valid_next = b_valid_reg;
        if (a_move)
        begin
            b_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            b_valid_next = 1'b0;
        end
    end

    // Result word: error pattern on a bad descriptor, zero for unseen vectors
    always_comb
    begin
        vec_t acc;
        vec_t gyr;

        if (a_status_reg == STATUS_BAD_DESC)
        begin
            acc = {3{ERROR_WORD}};
            gyr = {3{ERROR_WORD}};
        end
        else
        begin
            acc = a_seen_reg[0] ? accel_vec : '0;
            gyr = a_seen_reg[1] ? gyro_vec  : '0;
        end
        b_data_next = {4'b0000, a_seen_reg,
                       gyr[31:0], gyr[63:32], gyr[95:64],
                       acc[31:0], acc[63:32], acc[95:64],
                       a_status_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            a_status_reg <= emit_status;
            a_seen_reg   <= (emit_status == STATUS_BAD_DESC) ? 2'b00 : seen_next;
        end
        if (a_move)
        begin
            b_data_reg <= b_data_next;
        end
    end

    // Bytes dropped while waiting for a packet start never request a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !s_tuser[0] && ignore_reg |-> !emit)
        else $error("result requested while ignoring bytes");

    // A pending result in stage A is not lost while the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        a_valid_reg && !a_move |=> a_valid_reg)
        else $error("stage A result dropped");

    // A bad descriptor result carries no seen flags
    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_data_reg[1:0] == STATUS_BAD_DESC |-> b_data_reg[195:194] == 2'b00)
        else $error("seen flags set on a bad descriptor result");

    // After a result request the walker ignores bytes until the next start
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> ignore_reg)
        else $error("walker still active after a result");

endmodule

`default_nettype wire

### hdl/ipfp_vec_store.sv
// Vector store of the IMU packet field parser: a two-entry memory of
// completed accel and gyro vectors, read on request. Depends on ipfp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ipfp_vec_store
    import ipfp_pkg::*;
(
    input  wire logic    clk,
    input  wire commit_t commit,    // vector completed this cycle
    input  wire logic    rd_en,     // result request: read both slots
    output      vec_t    accel_vec,
    output      vec_t    gyro_vec
);

    vec_t    mem [0:1];
    vec_t    rd_accel_reg;
    vec_t    rd_gyro_reg;
    commit_t fwd_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (commit.valid)
        begin
            mem[commit.slot] <= commit.data;
        end
    end

    // Read ports, registered; a write in the same cycle is kept for bypass
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_accel_reg <= mem[SLOT_ACCEL];
            rd_gyro_reg  <= mem[SLOT_GYRO];
            fwd_reg      <= commit;
        end
    end

    // Bypass: a vector completed on the result's own byte is not yet in memory
    always_comb
    begin
        accel_vec = rd_accel_reg;
        gyro_vec  = rd_gyro_reg;
        if (fwd_reg.valid && fwd_reg.slot == SLOT_ACCEL)
        begin
            accel_vec = fwd_reg.data;
        end
        if (fwd_reg.valid && fwd_reg.slot == SLOT_GYRO)
        begin
            gyro_vec = fwd_reg.data;
        end
    end

endmodule

`default_nettype wire

### dv/tb_top.sv
// Testbench for imu_packet_field_parser: a directed table with typed expectations,
// then random packets checked against a behavioural packet walker held here.
// Depends on ipfp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_top;
    import ipfp_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int ITEM_TARGET  = 1750;
    localparam int DRAIN_CYCLES = 20;

    // Expected outcome of a directed row; EXP_MODEL defers to the predictor
    typedef enum logic [2:0] {
        EXP_MODEL,
        EXP_NONE,
        EXP_DESC_ERR,
        EXP_EMPTY_OK,
        EXP_EMPTY_BAD_LEN
    } exp_mode_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       start;
        exp_mode_t  mode;
    } stim_row_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] ax, ay, az;
        logic [31:0] gx, gy, gz;
        logic        accel_seen;
        logic        gyro_seen;
    } imu_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata = 8'h00;   // [7:0] rx_byte
    logic [0:0]       s_tuser = 1'b0;    // [0] packet_start
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;           // status, accel xyz, gyro xyz, seen flags

    // Packet walker state
    logic [8:0]  pos_r;
    logic [7:0]  plen_r, foff_r, flen_r, fkind_r;
    logic [31:0] cap_r[3];
    logic [31:0] acc_r[3];
    logic [31:0] gyr_r[3];
    logic [1:0]  seen_r;
    bit          idle_wait_r;

    imu_result_t pending_results[$];

    int cycles;
    int errors;
    int live_bytes, dropped_bytes;
    int results_due, results_got;
    int n_desc_err, n_len_err, n_accel, n_gyro;
    bit src_calm, sink_calm;

    // Directed rows: stray bytes, bad descriptor, dropped packet, empty payload,
    // field length below two, a short accel field
    stim_row_t dir_rows[24] = '{
        '{8'hFF, 1'b0, EXP_NONE},
        '{8'h00, 1'b0, EXP_NONE},
        '{8'h75, 1'b1, EXP_NONE},
        '{8'h65, 1'b0, EXP_NONE},
        '{8'h00, 1'b0, EXP_DESC_ERR},
        '{8'hAA, 1'b0, EXP_NONE},
        '{8'h75, 1'b1, EXP_NONE},
        '{8'h65, 1'b0, EXP_NONE},
        '{8'h75, 1'b1, EXP_NONE},
        '{8'h65, 1'b0, EXP_NONE},
        '{8'h80, 1'b0, EXP_NONE},
        '{8'h00, 1'b0, EXP_EMPTY_OK},
        '{8'h75, 1'b1, EXP_NONE},
        '{8'h65, 1'b0, EXP_NONE},
        '{8'h80, 1'b0, EXP_NONE},
        '{8'h05, 1'b0, EXP_NONE},
        '{8'h01, 1'b0, EXP_EMPTY_BAD_LEN},
        '{8'h75, 1'b1, EXP_NONE},
        '{8'h65, 1'b0, EXP_NONE},
        '{8'h80, 1'b0, EXP_NONE},
        '{8'h02, 1'b0, EXP_NONE},
        '{8'h02, 1'b0, EXP_NONE},
        '{8'h04, 1'b0, EXP_EMPTY_OK},
        '{8'hFF, 1'b1, EXP_MODEL}
    };

    imu_packet_field_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Builds the packet result and stops the walker until the next start
    function automatic imu_result_t close_packet(status_t st, bit err_words);
        imu_result_t r;
        r.status     = st;
        r.ax         = err_words ? ERROR_WORD : acc_r[0];
        r.ay         = err_words ? ERROR_WORD : acc_r[1];
        r.az         = err_words ? ERROR_WORD : acc_r[2];
        r.gx         = err_words ? ERROR_WORD : gyr_r[0];
        r.gy         = err_words ? ERROR_WORD : gyr_r[1];
        r.gz         = err_words ? ERROR_WORD : gyr_r[2];
        r.accel_seen = err_words ? 1'b0 : seen_r[0];
        r.gyro_seen  = err_words ? 1'b0 : seen_r[1];
        idle_wait_r  = 1'b1;
        return r;
    endfunction

    // Walks one byte; returns 0 when the byte is dropped
    function automatic bit parse_byte(input logic [7:0] b, input logic st,
                                      output bit fired, output imu_result_t res);
        logic [8:0] pos;
        logic [1:0] w;
        fired = 1'b0;
        res   = '0;
        if (st)
        begin
            pos_r       = '0;
            acc_r       = '{default: '0};
            gyr_r       = '{default: '0};
            seen_r      = '0;
            idle_wait_r = 1'b0;
        end
        else if (idle_wait_r)
            return 1'b0;

        pos = pos_r;
        if (pos_r < 9'd511)
            pos_r = pos_r + 9'd1;

        if (pos == 9'd2)
        begin
            if (b != PKT_DESC_IMU)
            begin
                fired = 1'b1;
                res   = close_packet(STATUS_BAD_DESC, 1'b1);
            end
        end
        else if (pos == 9'd3)
        begin
            plen_r = b;
            foff_r = '0;
            if (b == 8'd0)
            begin
                fired = 1'b1;
                res   = close_packet(STATUS_OK, 1'b0);
            end
        end
        else if (pos >= 9'd4)
        begin
            if (foff_r == 8'd0)
            begin
                flen_r = b;
                if (b < MIN_FIELD_LEN)
                begin
                    fired = 1'b1;
                    res   = close_packet(STATUS_BAD_LEN, 1'b0);
                    return 1'b1;
                end
            end
            else if (foff_r == 8'd1)
                fkind_r = b;
            else if (foff_r <= CAP_LAST && flen_r >= MIN_VEC_LEN &&
                     (fkind_r == FIELD_ACCEL || fkind_r == FIELD_GYRO))
            begin
                // big-endian words: shift each byte in from the bottom
                w = 2'((foff_r - CAP_FIRST) >> 2);
                cap_r[w] = {cap_r[w][23:0], b};
                if (foff_r == CAP_LAST)
                begin
                    if (fkind_r == FIELD_ACCEL)
                    begin
                        acc_r     = cap_r;
                        seen_r[0] = 1'b1;
                    end
                    else
                    begin
                        gyr_r     = cap_r;
                        seen_r[1] = 1'b1;
                    end
                end
            end
            foff_r = foff_r + 8'd1;
            if (foff_r == flen_r)
                foff_r = '0;
            if (int'(pos) == 3 + int'(plen_r))
            begin
                fired = 1'b1;
                res   = close_packet(STATUS_OK, 1'b0);
            end
        end
        return 1'b1;
    endfunction

    // Offers one byte after a random gap, waits for the request to be taken,
    // then files what the parser should answer
    task automatic push_byte(input logic [7:0] b, input logic st, input exp_mode_t mode);
        int          gap;
        bit          fired, live;
        imu_result_t res;
        if ($urandom_range(0, 15) == 0)
            src_calm = ~src_calm;
        gap = src_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);

        live = parse_byte(b, st, fired, res);
        if (live)
            live_bytes++;
        else
            dropped_bytes++;

        // typed expectations for the directed rows
        case (mode)
            EXP_NONE:          fired = 1'b0;
            EXP_DESC_ERR:
            begin
                res = '{STATUS_BAD_DESC, ERROR_WORD, ERROR_WORD, ERROR_WORD,
                        ERROR_WORD, ERROR_WORD, ERROR_WORD, 1'b0, 1'b0};
                fired = 1'b1;
            end
            EXP_EMPTY_OK:
            begin
                res   = '0;
                fired = 1'b1;
            end
            EXP_EMPTY_BAD_LEN:
            begin
                res        = '0;
                res.status = STATUS_BAD_LEN;
                fired      = 1'b1;
            end
            default: ;
        endcase

        if (fired)
        begin
            pending_results.push_back(res);
            results_due++;
            if (res.status == STATUS_BAD_DESC) n_desc_err++;
            if (res.status == STATUS_BAD_LEN)  n_len_err++;
            if (res.accel_seen) n_accel++;
            if (res.gyro_seen)  n_gyro++;
        end
    endtask

    // One packet: mostly well formed, with bad sync, bad descriptor, length
    // mismatch, malformed fields and truncation mixed in
    task automatic send_random_packet();
        logic [7:0] body[$];
        logic [7:0] pkt[$];
        logic [7:0] kind;
        int         nfields, flen, r, plen, keep, noise;
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)      flen = $urandom_range(14, 18);
            else if (r < 80) flen = $urandom_range(2, 13);
            else if (r < 92) flen = $urandom_range(19, 40);
            else if (r < 98) flen = $urandom_range(0, 1);
            else             flen = $urandom_range(41, 255);
            r = $urandom_range(0, 9);
            if (r < 4)      kind = FIELD_ACCEL;
            else if (r < 8) kind = FIELD_GYRO;
            else            kind = 8'($urandom_range(0, 255));
            body.push_back(8'(flen));
            body.push_back(kind);
            for (int k = 2; k < flen; k++)
                body.push_back(8'($urandom_range(0, 255)));
        end
        while (body.size() > 255)
            void'(body.pop_back());

        r = $urandom_range(0, 99);
        if (r < 85)      plen = body.size();
        else if (r < 95) plen = $urandom_range(0, 255);
        else             plen = 0;

        // sync, descriptor, length, payload, checksum
        r = $urandom_range(0, 99);
        pkt.push_back(r < 85 ? 8'h75 : 8'($urandom_range(0, 255)));
        pkt.push_back(r < 85 ? 8'h65 : 8'($urandom_range(0, 255)));
        pkt.push_back($urandom_range(0, 9) != 0 ? PKT_DESC_IMU : 8'($urandom_range(0, 255)));
        pkt.push_back(8'(plen));
        foreach (body[i])
            pkt.push_back(body[i]);
        pkt.push_back(8'($urandom_range(0, 255)));
        pkt.push_back(8'($urandom_range(0, 255)));

        keep = pkt.size();
        if ($urandom_range(0, 19) == 0)
            keep = $urandom_range(1, pkt.size());
        for (int i = 0; i < keep; i++)
            push_byte(pkt[i], i == 0, EXP_MODEL);

        // line noise between packets
        if ($urandom_range(0, 3) == 0)
        begin
            noise = $urandom_range(1, 3);
            repeat (noise) push_byte(8'($urandom_range(0, 255)), 1'b0, EXP_MODEL);
        end
    endtask

    // Result side: random stalls between requests, with calm stretches
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 7) == 0)
                sink_calm = ~sink_calm;
            stall = sink_calm ? 0 : $urandom_range(0, 15);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!(m_tvalid && m_tready))
                @(posedge clk);
        end
    end

    function automatic void check_word(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            errors++;
        end
    endfunction

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        imu_result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status     = status_t'(m_tdata[1:0]);
            got.ax         = m_tdata[33:2];
            got.ay         = m_tdata[65:34];
            got.az         = m_tdata[97:66];
            got.gx         = m_tdata[129:98];
            got.gy         = m_tdata[161:130];
            got.gz         = m_tdata[193:162];
            got.accel_seen = m_tdata[194];
            got.gyro_seen  = m_tdata[195];
            results_got++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d", got.status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_word("status", 32'(want.status), 32'(got.status));
                check_word("accel_x", want.ax, got.ax);
                check_word("accel_y", want.ay, got.ay);
                check_word("accel_z", want.az, got.az);
                check_word("gyro_x", want.gx, got.gx);
                check_word("gyro_y", want.gy, got.gy);
                check_word("gyro_z", want.gz, got.gz);
                check_word("accel_seen", 32'(want.accel_seen), 32'(got.accel_seen));
                check_word("gyro_seen", 32'(want.gyro_seen), 32'(got.gyro_seen));
            end
        end
    end

    // Main sequence
    initial
    begin : stimulus
        pos_r       = '0;
        plen_r      = '0;
        foff_r      = '0;
        flen_r      = '0;
        fkind_r     = '0;
        cap_r       = '{default: '0};
        acc_r       = '{default: '0};
        gyr_r       = '{default: '0};
        seen_r      = '0;
        idle_wait_r = 1'b1;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            push_byte(dir_rows[i].rx, dir_rows[i].start, dir_rows[i].mode);

        while (live_bytes + dropped_bytes < ITEM_TARGET)
            send_random_packet();
        s_tvalid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Walked %0d packet bytes, %0d dropped outside packets; %0d of %0d results checked",
                 live_bytes, dropped_bytes, results_got, results_due);
        $display("Results: %0d bad descriptor, %0d bad field length, %0d accel, %0d gyro",
                 n_desc_err, n_len_err, n_accel, n_gyro);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
